### rtl/core/ps2mct_pkg.sv
`default_nettype none
package ps2mct_pkg;

  // Command codes carried in the input tuser
  localparam logic [1:0] CMD_DATA     = 2'd0;
  localparam logic [1:0] CMD_READ     = 2'd1;
  localparam logic [1:0] CMD_RECENTER = 2'd2;

  // Configuration register indexes
  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  localparam int          BOUND_REG_W = 13;
  localparam logic [12:0] WIDTH_RST   = 13'd1024;
  localparam logic [12:0] HEIGHT_RST  = 13'd768;

  // Flag byte layout
  localparam int         SYNC_BIT   = 3;
  localparam int         X_SIGN_BIT = 4;
  localparam int         Y_SIGN_BIT = 5;
  localparam logic [7:0] OVF_MASK   = 8'hC0;

  localparam logic [1:0] POS_FLAG  = 2'd0;
  localparam logic [1:0] POS_XBYTE = 2'd1;
  localparam logic [1:0] POS_YBYTE = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } in_item_t;

  // Ordered so that {flags, pos_y, pos_x} packs the result word lowest field first
  typedef struct packed {
    logic       sync_dropped;
    logic       overflow_dropped;
    logic       packet_done;
    logic [2:0] release_mask;
    logic       released_flag;
    logic [2:0] click_mask;
    logic       clicked_flag;
    logic       moved_flag;
    logic [2:0] buttons_now;
  } flags_t;

endpackage
`default_nettype wire

### rtl/core/ps2mct_in_reg.sv
`default_nettype none
module ps2mct_in_reg (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  ps2mct_pkg::in_item_t   in_item,
  input  wire                    adv,
  output logic                   hold_valid,
  output ps2mct_pkg::in_item_t   hold_item
);
  import ps2mct_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // Take a new transaction when none is held or the held one leaves in the same cycle
  assign in_ready   = !valid_r || adv;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

### rtl/core/ps2mct_axis_step.sv
`default_nettype none
module ps2mct_axis_step #(
  parameter int COORD_BITS = 12
) (
  input  wire        [COORD_BITS-1:0] pos,
  input  wire signed [9:0]            delta,
  input  wire        [COORD_BITS:0]   bound,
  output logic       [COORD_BITS-1:0] new_pos
);
  localparam int SW = COORD_BITS + 2;

  logic signed [SW-1:0] sum;
  logic        [SW-1:0] bound_ext;
  logic        [COORD_BITS:0] last;

  assign sum       = $signed({2'b00, pos}) + SW'(delta);
  assign bound_ext = SW'(bound);
  assign last      = bound - 1'b1;

  // Clamp to 0 .. bound-1; bound is never zero here
  always_comb begin
    if (sum < 0) begin
      new_pos = '0;
    end else if ($unsigned(sum) >= bound_ext) begin
      new_pos = last[COORD_BITS-1:0];
    end else begin
      new_pos = sum[COORD_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

### rtl/core/ps2mct_tracker.sv
`default_nettype none
module ps2mct_tracker #(
  parameter int COORD_BITS = 12
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              hold_valid,
  input  ps2mct_pkg::in_item_t             hold_item,
  output logic                             adv,
  input  wire [ps2mct_pkg::BOUND_REG_W-1:0] width_reg,
  input  wire [ps2mct_pkg::BOUND_REG_W-1:0] height_reg,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [COORD_BITS-1:0]            pos_x,
  output logic [COORD_BITS-1:0]            pos_y,
  output ps2mct_pkg::flags_t               flags
);
  import ps2mct_pkg::*;

  localparam int CW = (COORD_BITS + 1 > BOUND_REG_W) ? COORD_BITS + 1 : BOUND_REG_W;
  localparam logic [CW-1:0] LIMIT = CW'(1) << COORD_BITS;

  function automatic logic [COORD_BITS:0] eff_bound(input logic [BOUND_REG_W-1:0] r);
    logic [CW-1:0] v;
    v = CW'(r);
    if (v > LIMIT) v = LIMIT;
    if (v == '0) v = CW'(1);
    return v[COORD_BITS:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] half(input logic [COORD_BITS:0] b);
    logic [COORD_BITS:0] h;
    h = b >> 1;
    return h[COORD_BITS-1:0];
  endfunction

  logic [1:0]            byte_pos_r, byte_pos_nxt;
  logic [7:0]            flag_byte_r, flag_byte_nxt;
  logic [7:0]            xbyte_r, xbyte_nxt;
  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0] cur_y_r, cur_y_nxt;
  logic [2:0]            held_r, held_nxt;
  logic                  moved_r, moved_nxt;
  logic                  clicked_r, clicked_nxt;
  logic [2:0]            cmask_r, cmask_nxt;
  logic                  released_r, released_nxt;
  logic [2:0]            rmask_r, rmask_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] pos_x_r, pos_y_r;
  flags_t                flags_r, flags_nxt;

  logic [COORD_BITS:0]   bound_x, bound_y;
  logic signed [9:0]     dx, dy, neg_dy;
  logic [COORD_BITS-1:0] step_x, step_y;
  logic [1:0]            pos_eff;
  logic [2:0]            pressed, released;
  logic                  done, ovf, syn;

  assign bound_x = eff_bound(width_reg);
  assign bound_y = eff_bound(height_reg);

  assign dx     = $signed({{2{flag_byte_r[X_SIGN_BIT]}}, xbyte_r});
  assign dy     = $signed({{2{flag_byte_r[Y_SIGN_BIT]}}, hold_item.data_byte});
  assign neg_dy = -dy;

  ps2mct_axis_step #(.COORD_BITS(COORD_BITS)) u_step_x (
    .pos     (cur_x_r),
    .delta   (dx),
    .bound   (bound_x),
    .new_pos (step_x)
  );

  ps2mct_axis_step #(.COORD_BITS(COORD_BITS)) u_step_y (
    .pos     (cur_y_r),
    .delta   (neg_dy),
    .bound   (bound_y),
    .new_pos (step_y)
  );

  assign adv      = hold_valid && (!out_valid_r || out_ready);
  assign pos_eff  = (byte_pos_r == 2'd3) ? POS_FLAG : byte_pos_r;
  assign pressed  = flag_byte_r[2:0] & ~held_r;
  assign released = held_r & ~flag_byte_r[2:0];

  always_comb begin
    byte_pos_nxt  = pos_eff;
    flag_byte_nxt = flag_byte_r;
    xbyte_nxt     = xbyte_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    held_nxt      = held_r;
    moved_nxt     = moved_r;
    clicked_nxt   = clicked_r;
    cmask_nxt     = cmask_r;
    released_nxt  = released_r;
    rmask_nxt     = rmask_r;
    done          = 1'b0;
    ovf           = 1'b0;
    syn           = 1'b0;
    unique case (hold_item.command)
      CMD_READ: begin
        moved_nxt    = 1'b0;
        clicked_nxt  = 1'b0;
        cmask_nxt    = '0;
        released_nxt = 1'b0;
        rmask_nxt    = '0;
      end
      CMD_RECENTER: begin
        byte_pos_nxt = byte_pos_r;
        cur_x_nxt    = half(bound_x);
        cur_y_nxt    = half(bound_y);
        held_nxt     = '0;
      end
      CMD_DATA: begin
        unique case (pos_eff)
          POS_FLAG: begin
            if (!hold_item.data_byte[SYNC_BIT]) begin
              syn = 1'b1;
            end else begin
              flag_byte_nxt = hold_item.data_byte;
              byte_pos_nxt  = POS_XBYTE;
            end
          end
          POS_XBYTE: begin
            xbyte_nxt    = hold_item.data_byte;
            byte_pos_nxt = POS_YBYTE;
          end
          default: begin
            byte_pos_nxt = POS_FLAG;
            if ((flag_byte_r & OVF_MASK) != '0) begin
              ovf = 1'b1;
            end else begin
              done      = 1'b1;
              cur_x_nxt = step_x;
              cur_y_nxt = step_y;
              held_nxt  = flag_byte_r[2:0];
              if (step_x != cur_x_r || step_y != cur_y_r) moved_nxt = 1'b1;
              if (pressed != '0) begin
                clicked_nxt = 1'b1;
                cmask_nxt   = pressed;
              end
              if (released != '0) begin
                released_nxt = 1'b1;
                rmask_nxt    = released;
              end
            end
          end
        endcase
      end
      default: begin
        byte_pos_nxt = byte_pos_r;
      end
    endcase
  end

  // A read reports the latches as they were before the clear
  always_comb begin
    flags_nxt.buttons_now      = held_nxt;
    flags_nxt.packet_done      = done;
    flags_nxt.overflow_dropped = ovf;
    flags_nxt.sync_dropped     = syn;
    if (hold_item.command == CMD_READ) begin
      flags_nxt.moved_flag    = moved_r;
      flags_nxt.clicked_flag  = clicked_r;
      flags_nxt.click_mask    = cmask_r;
      flags_nxt.released_flag = released_r;
      flags_nxt.release_mask  = rmask_r;
    end else begin
      flags_nxt.moved_flag    = moved_nxt;
      flags_nxt.clicked_flag  = clicked_nxt;
      flags_nxt.click_mask    = cmask_nxt;
      flags_nxt.released_flag = released_nxt;
      flags_nxt.release_mask  = rmask_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= POS_FLAG;
      flag_byte_r <= '0;
      xbyte_r     <= '0;
      cur_x_r     <= half(eff_bound(WIDTH_RST));
      cur_y_r     <= half(eff_bound(HEIGHT_RST));
      held_r      <= '0;
      moved_r     <= 1'b0;
      clicked_r   <= 1'b0;
      cmask_r     <= '0;
      released_r  <= 1'b0;
      rmask_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        byte_pos_r  <= byte_pos_nxt;
        flag_byte_r <= flag_byte_nxt;
        xbyte_r     <= xbyte_nxt;
        cur_x_r     <= cur_x_nxt;
        cur_y_r     <= cur_y_nxt;
        held_r      <= held_nxt;
        moved_r     <= moved_nxt;
        clicked_r   <= clicked_nxt;
        cmask_r     <= cmask_nxt;
        released_r  <= released_nxt;
        rmask_r     <= rmask_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x_r <= cur_x_nxt;
      pos_y_r <= cur_y_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign pos_x     = pos_x_r;
  assign pos_y     = pos_y_r;
  assign flags     = flags_r;

endmodule
`default_nettype wire

### rtl/core/ps2_mouse_packet_cursor_tracker.sv
`default_nettype none
// Channel   Direction  Payload
// in_*      input      tuser: command[1:0]; tdata: data_byte[7:0]
// out_*     output     tdata: pos_x, pos_y, buttons_now, moved/clicked flags, masks,
//                      released flag, packet_done, overflow_dropped, sync_dropped
// cfg_*     input      cfg_index selects screen_width (0) or screen_height (1)
//
// One transaction per cycle while the output is not stalled; a result reaches out_* through
// the input register, which takes the transaction, and then the result register, which
// takes the decode/clamp output.
// Reset puts the bounds at 1024 x 768 and the cursor at half of each bound.
// A stalled output holds its result; the input register keeps taking transactions
// as long as the held one can move into the result register in the same cycle.
module ps2_mouse_packet_cursor_tracker #(
  parameter int COORD_BITS = 12
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire [1:0]                         in_tuser,   // command
  input  wire [7:0]                         in_tdata,   // data_byte
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // pos_x, pos_y, buttons_now[2:0], moved_flag, clicked_flag, click_mask[2:0],
  // released_flag, release_mask[2:0], packet_done, overflow_dropped, sync_dropped, pad
  output logic [((2*COORD_BITS+15+7)/8)*8-1:0] out_tdata,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [0:0]                         cfg_index,
  input  wire [ps2mct_pkg::BOUND_REG_W-1:0] cfg_data
);
  import ps2mct_pkg::*;

  localparam int OUT_W = ((2*COORD_BITS + 15 + 7) / 8) * 8;

  logic [BOUND_REG_W-1:0] width_r, height_r;
  in_item_t               in_item, hold_item;
  logic                   hold_valid;
  logic                   adv;
  logic [COORD_BITS-1:0]  pos_x, pos_y;
  flags_t                 flags;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item.command   = in_tuser;
  assign in_item.data_byte = in_tdata;

  ps2mct_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .adv        (adv),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  ps2mct_tracker #(.COORD_BITS(COORD_BITS)) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .adv        (adv),
    .width_reg  (width_r),
    .height_reg (height_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .flags      (flags)
  );

  assign out_tdata = OUT_W'({flags, pos_y, pos_x});

  // At most one per-byte outcome in a result
  a_outcome_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0({flags.packet_done, flags.overflow_dropped,
                             flags.sync_dropped}))
    else $error("more than one byte outcome flagged");

  // An accepted packet leaves the cursor inside the horizontal bound
  a_x_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && flags.packet_done |->
      (COORD_BITS+1)'(pos_x) < (COORD_BITS+1)'(width_r) || pos_x == '0 ||
      (COORD_BITS+1)'(width_r) > ((COORD_BITS+1)'(1) << COORD_BITS) ||
      width_r > BOUND_REG_W'((1 << COORD_BITS) - 1))
    else $error("cursor x outside bound after packet");

  // A held transaction is not lost while the result register is stalled
  a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid && out_tvalid && !out_tready |=> hold_valid)
    else $error("held transaction dropped during output stall");

endmodule
`default_nettype wire
